@@ design/cshx_pkg.sv @@
// cshx_pkg: shared types, constants and helper functions for the CRC-stamped
// Intel HEX encoder. Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package cshx_pkg;

  localparam int unsigned IMAGE_BYTES = 393216;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  localparam logic [6:0] CH_COLON = 7'h3A;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_ONE   = 7'h31;
  localparam logic [6:0] CH_TWO   = 7'h32;
  localparam logic [6:0] CH_FOUR  = 7'h34;
  localparam logic [6:0] CH_F     = 7'h46;
  localparam logic [6:0] CH_CR    = 7'h0D;
  localparam logic [6:0] CH_LF    = 7'h0A;

  // Text work for one image byte: which records to write and their values
  typedef struct packed {
    logic        ext;
    logic        hdr;
    logic        trl;
    logic        fin;
    logic [15:0] seg;
    logic [7:0]  ext_ck;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  rec_ck;
  } job_t;

  function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [6:0] hex_char(input logic [3:0] v);
    logic [6:0] r;
    if (v < 4'd10) begin
      r = CH_ZERO + {3'd0, v};
    end else begin
      r = 7'h37 + {3'd0, v};
    end
    return r;
  endfunction

endpackage

@@ design/cshx_front.sv @@
// cshx_front: image byte intake, CRC-32, offset and checksum tracking.
// Produces one registered job per byte for the character emitter. Uses cshx_pkg.
`timescale 1ns / 1ps

module cshx_front #(
  parameter int unsigned IMAGE_BYTES = cshx_pkg::IMAGE_BYTES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic [31:0]        load_address,
  output logic               job_valid,
  output cshx_pkg::job_t     job,
  input  logic               take
);

  localparam int unsigned PosW = $clog2(IMAGE_BYTES);
  localparam logic [PosW-1:0] LastPos = PosW'(IMAGE_BYTES - 1);
  localparam logic [PosW-1:0] CrcEnd  = PosW'(IMAGE_BYTES - 4);

  logic [31:0]     crc;
  logic [PosW-1:0] pos;
  logic [7:0]      rec_sum;
  logic [15:0]     segment;

  logic            accept;
  logic [15:0]     seg_next;
  logic [7:0]      ck_base;
  logic [7:0]      b;
  logic [7:0]      rec_sum_next;
  logic [1:0]      tail;
  logic [31:0]     crc_out;
  cshx_pkg::job_t  job_next;

  assign in_stall = job_valid && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    seg_next = (pos == '0) ? load_address[31:16] : 16'(segment + 16'd1);
    ck_base  = (pos[3:0] == 4'd0) ? 8'(8'd16 + pos[15:8] + pos[7:0]) : rec_sum;
    tail     = 2'(LastPos[1:0] - pos[1:0]);
    crc_out  = ~crc;
    case (tail)
      2'd0:    b = crc_out[7:0];
      2'd1:    b = crc_out[15:8];
      2'd2:    b = crc_out[23:16];
      default: b = crc_out[31:24];
    endcase
    if (pos < CrcEnd) begin
      b = data_byte;
    end
    rec_sum_next = 8'(ck_base + b);

    job_next.ext    = (pos[15:0] == 16'd0);
    job_next.hdr    = (pos[3:0] == 4'd0);
    job_next.trl    = (pos[3:0] == 4'd15);
    job_next.fin    = (pos == LastPos);
    job_next.seg    = seg_next;
    job_next.ext_ck = 8'(8'd0 - 8'd6 - seg_next[15:8] - seg_next[7:0]);
    job_next.addr   = pos[15:0];
    job_next.data   = b;
    job_next.rec_ck = 8'(8'd0 - rec_sum_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      crc       <= cshx_pkg::CRC_INIT;
      pos       <= '0;
      rec_sum   <= 8'd0;
      segment   <= 16'd0;
    end else if (accept) begin
      job_valid <= 1'b1;
      if (pos == LastPos) begin
        crc     <= cshx_pkg::CRC_INIT;
        pos     <= '0;
        rec_sum <= 8'd0;
        segment <= 16'd0;
      end else begin
        if (pos < CrcEnd) begin
          crc <= cshx_pkg::crc32_step(crc, data_byte);
        end
        pos     <= pos + PosW'(1);
        rec_sum <= rec_sum_next;
        if (pos[15:0] == 16'd0) begin
          segment <= seg_next;
        end
      end
    end else if (take) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= job_next;
    end
  end

endmodule

@@ design/cshx_emit.sv @@
// cshx_emit: walks the records of one job and drives one ASCII character per
// cycle into the output register while out_stall is low. Uses cshx_pkg.
`timescale 1ns / 1ps

module cshx_emit (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  cshx_pkg::job_t     job_in,
  output logic               take,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         out_char,
  output logic               run_last,
  output logic               image_done
);

  localparam logic [2:0] PH_EXT  = 3'd0;
  localparam logic [2:0] PH_HDR  = 3'd1;
  localparam logic [2:0] PH_BYTE = 3'd2;
  localparam logic [2:0] PH_TRL  = 3'd3;
  localparam logic [2:0] PH_FIN  = 3'd4;

  localparam logic [4:0] EXT_END  = 5'd16;
  localparam logic [4:0] HDR_END  = 5'd8;
  localparam logic [4:0] BYTE_END = 5'd1;
  localparam logic [4:0] TRL_END  = 5'd3;
  localparam logic [4:0] FIN_END  = 5'd12;

  logic           busy;
  cshx_pkg::job_t job;
  logic [2:0]     phase;
  logic [4:0]     idx;

  logic           adv;
  logic           phase_end;
  logic           has_next;
  logic           last;
  logic [2:0]     phase_next;
  logic [2:0]     start_phase;
  logic [6:0]     ch;

  assign adv  = !out_valid || !out_stall;
  assign last = phase_end && !has_next;
  assign take = job_valid && (!busy || (adv && last));

  assign start_phase = job_in.ext ? PH_EXT : (job_in.hdr ? PH_HDR : PH_BYTE);

  always_comb begin
    phase_end  = 1'b0;
    has_next   = 1'b0;
    phase_next = PH_BYTE;
    ch         = cshx_pkg::CH_ZERO;
    case (phase)
      PH_EXT: begin
        phase_end  = (idx == EXT_END);
        has_next   = 1'b1;
        phase_next = job.hdr ? PH_HDR : PH_BYTE;
        case (idx)
          5'd0:    ch = cshx_pkg::CH_COLON;
          5'd2:    ch = cshx_pkg::CH_TWO;
          5'd8:    ch = cshx_pkg::CH_FOUR;
          5'd9:    ch = cshx_pkg::hex_char(job.seg[15:12]);
          5'd10:   ch = cshx_pkg::hex_char(job.seg[11:8]);
          5'd11:   ch = cshx_pkg::hex_char(job.seg[7:4]);
          5'd12:   ch = cshx_pkg::hex_char(job.seg[3:0]);
          5'd13:   ch = cshx_pkg::hex_char(job.ext_ck[7:4]);
          5'd14:   ch = cshx_pkg::hex_char(job.ext_ck[3:0]);
          5'd15:   ch = cshx_pkg::CH_CR;
          5'd16:   ch = cshx_pkg::CH_LF;
          default: ch = cshx_pkg::CH_ZERO;
        endcase
      end
      PH_HDR: begin
        phase_end  = (idx == HDR_END);
        has_next   = 1'b1;
        phase_next = PH_BYTE;
        case (idx)
          5'd0:    ch = cshx_pkg::CH_COLON;
          5'd1:    ch = cshx_pkg::CH_ONE;
          5'd3:    ch = cshx_pkg::hex_char(job.addr[15:12]);
          5'd4:    ch = cshx_pkg::hex_char(job.addr[11:8]);
          5'd5:    ch = cshx_pkg::hex_char(job.addr[7:4]);
          5'd6:    ch = cshx_pkg::hex_char(job.addr[3:0]);
          default: ch = cshx_pkg::CH_ZERO;
        endcase
      end
      PH_BYTE: begin
        phase_end  = (idx == BYTE_END);
        has_next   = job.trl || job.fin;
        phase_next = job.trl ? PH_TRL : PH_FIN;
        ch = (idx == 5'd0) ? cshx_pkg::hex_char(job.data[7:4])
                           : cshx_pkg::hex_char(job.data[3:0]);
      end
      PH_TRL: begin
        phase_end  = (idx == TRL_END);
        has_next   = job.fin;
        phase_next = PH_FIN;
        case (idx)
          5'd0:    ch = cshx_pkg::hex_char(job.rec_ck[7:4]);
          5'd1:    ch = cshx_pkg::hex_char(job.rec_ck[3:0]);
          5'd2:    ch = cshx_pkg::CH_CR;
          default: ch = cshx_pkg::CH_LF;
        endcase
      end
      PH_FIN: begin
        phase_end = (idx == FIN_END);
        case (idx)
          5'd0:    ch = cshx_pkg::CH_COLON;
          5'd8:    ch = cshx_pkg::CH_ONE;
          5'd9:    ch = cshx_pkg::CH_F;
          5'd10:   ch = cshx_pkg::CH_F;
          5'd11:   ch = cshx_pkg::CH_CR;
          5'd12:   ch = cshx_pkg::CH_LF;
          default: ch = cshx_pkg::CH_ZERO;
        endcase
      end
      default: begin
        phase_end = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      phase     <= PH_EXT;
      idx       <= 5'd0;
    end else begin
      if (adv) begin
        out_valid <= busy;
      end
      if (take) begin
        busy  <= 1'b1;
        phase <= start_phase;
        idx   <= 5'd0;
      end else if (adv && busy) begin
        if (last) begin
          busy <= 1'b0;
        end else if (phase_end) begin
          phase <= phase_next;
          idx   <= 5'd0;
        end else begin
          idx <= idx + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job <= job_in;
    end
    if (adv && busy) begin
      out_char   <= ch;
      run_last   <= last;
      image_done <= (phase == PH_FIN) && phase_end;
    end
  end

endmodule

@@ design/crc_stamped_intel_hex_encoder.sv @@
// crc_stamped_intel_hex_encoder: top level of the CRC-stamped Intel HEX encoder.
// Holds the load address register; instantiates cshx_front and cshx_emit.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_stall, data_byte            | byte in
//   out     | out_valid, out_stall, out_char,          | char out
//           | run_last, image_done                     |
//   cfg     | cfg_valid, cfg_ready, start_address      | write in
//
// One character leaves per cycle while out_stall is low; a byte causes 2 or more
// characters at the output register (about 3 on average).
// A new byte can enter before the previous byte's text is out; it is held in the
// job register while the emitter finishes the previous byte's text.
// Reset is synchronous; it clears the load address, CRC and position.
// out_stall holds the output character; in_stall rises while a job waits.
`timescale 1ns / 1ps

module crc_stamped_intel_hex_encoder #(
  parameter int unsigned IMAGE_BYTES = cshx_pkg::IMAGE_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_char,
  output logic        run_last,
  output logic        image_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] start_address
);

  logic [31:0]    load_address;
  logic           job_valid;
  logic           take;
  cshx_pkg::job_t job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_address <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      load_address <= start_address;
    end
  end

  cshx_front #(
    .IMAGE_BYTES(IMAGE_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .load_address (load_address),
    .job_valid    (job_valid),
    .job          (job),
    .take         (take)
  );

  cshx_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (job_valid),
    .job_in     (job),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .run_last   (run_last),
    .image_done (image_done)
  );

endmodule

@@ design/cshx_checker.sv @@
// cshx_checker: port-level assertions for crc_stamped_intel_hex_encoder,
// attached by bind below. Uses cshx_pkg.
`timescale 1ns / 1ps

module cshx_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] out_char,
  input logic       run_last,
  input logic       image_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(run_last))
    else $error("stalled output request changed");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && image_done |-> run_last)
    else $error("end of image not marked as last of its byte");

  a_done_lf: assert property (@(posedge clk) disable iff (rst)
    out_valid && image_done |-> out_char == cshx_pkg::CH_LF)
    else $error("end of image not on line feed");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind crc_stamped_intel_hex_encoder cshx_checker u_cshx_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_char   (out_char),
  .run_last   (run_last),
  .image_done (image_done)
);

@@ test/tb_crc_stamped_intel_hex_encoder.sv @@
// Testbench for crc_stamped_intel_hex_encoder: streams firmware images through the
// encoder and checks every HEX character against a built-in encoder model.
// Depends on design/cshx_pkg.sv and design/crc_stamped_intel_hex_encoder.sv.
`timescale 1ns / 1ps

module tb_crc_stamped_intel_hex_encoder;

  localparam int unsigned IMAGE_LEN      = 131072;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned MAX_PRINTS     = 40;

  typedef struct packed {
    logic [6:0] chr;
    logic       run_end;
    logic       img_end;
  } hex_out_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  out_char;
  logic        run_last;
  logic        image_done;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] start_address;

  // encoder model state
  logic [31:0] load_addr;
  logic [31:0] crc_acc;
  logic [31:0] byte_pos;
  logic [7:0]  rec_sum;
  logic [15:0] seg_hi;

  hex_out_t    hex_text_q[$];
  logic [6:0]  line_chars[$];

  int unsigned err_count;
  int unsigned char_count;
  int unsigned total_sent;
  int unsigned image_sent;
  int unsigned quiet_cycles;
  int unsigned cyc_count;
  int unsigned stall_left;

  crc_stamped_intel_hex_encoder #(
    .IMAGE_BYTES(IMAGE_LEN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char(out_char),
    .run_last(run_last),
    .image_done(image_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .start_address(start_address)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= MAX_PRINTS) begin
      $display("mismatch at char %0d: %s got %0h want %0h", char_count, what, got, want);
    end
  endtask

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ 32'hEDB8_8320;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [6:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) begin
      return 7'h30 + {3'd0, n};
    end
    return 7'h41 + {3'd0, n} - 7'd10;
  endfunction

  task automatic add_text(input string s);
    byte c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      line_chars.push_back(c[6:0]);
    end
  endtask

  task automatic add_hex(input logic [7:0] v);
    line_chars.push_back(hex_digit(v[7:4]));
    line_chars.push_back(hex_digit(v[3:0]));
  endtask

  task automatic add_eol();
    line_chars.push_back(cshx_pkg::CH_CR);
    line_chars.push_back(cshx_pkg::CH_LF);
  endtask

  task automatic clear_encoder();
    crc_acc  = 32'hFFFF_FFFF;
    byte_pos = '0;
    rec_sum  = '0;
    seg_hi   = '0;
  endtask

  // Work out the HEX text that one image byte produces
  task automatic encode_byte(input logic [7:0] din);
    logic [31:0] pos;
    logic [31:0] crc_word;
    logic [7:0]  b;
    logic        fin;
    int unsigned tail;
    int          n;
    pos = byte_pos;
    b = din;
    fin = 1'b0;
    line_chars.delete();
    if (pos[15:0] == 16'd0) begin
      if (pos == 0) begin
        seg_hi = load_addr[31:16];
      end else begin
        seg_hi = seg_hi + 16'd1;
      end
      add_text(":02000004");
      add_hex(seg_hi[15:8]);
      add_hex(seg_hi[7:0]);
      add_hex(8'd0 - (8'd6 + seg_hi[15:8] + seg_hi[7:0]));
      add_eol();
    end
    if (pos[3:0] == 4'd0) begin
      add_text(":10");
      add_hex(pos[15:8]);
      add_hex(pos[7:0]);
      add_text("00");
      rec_sum = 8'd16 + pos[15:8] + pos[7:0];
    end
    if (pos < IMAGE_LEN - 4) begin
      crc_acc = crc32_byte(crc_acc, din);
    end else begin
      tail = (IMAGE_LEN - 1 - pos) & 3;
      crc_word = ~crc_acc;
      b = 8'(crc_word >> (8 * tail));
    end
    add_hex(b);
    rec_sum = rec_sum + b;
    if (pos[3:0] == 4'd15) begin
      add_hex(8'd0 - rec_sum);
      add_eol();
    end
    if (pos >= IMAGE_LEN - 1) begin
      add_text(":00000001FF");
      add_eol();
      fin = 1'b1;
      clear_encoder();
    end else begin
      byte_pos = pos + 1;
    end
    n = line_chars.size();
    for (int i = 0; i < n; i++) begin
      hex_text_q.push_back('{chr: line_chars[i], run_end: (i == n - 1),
                             img_end: fin && (i == n - 1)});
    end
  endtask

  // Predict on accepted requests, check accepted characters
  always @(posedge clk) begin
    hex_out_t want;
    if (rst) begin
      load_addr = '0;
      clear_encoder();
    end else begin
      if (cfg_valid && cfg_ready) begin
        load_addr = start_address;
      end
      if (in_valid && !in_stall) begin
        encode_byte(data_byte);
      end
      if (out_valid && !out_stall) begin
        if (hex_text_q.size() == 0) begin
          report_mismatch("unexpected char", int'(out_char), 0);
        end else begin
          want = hex_text_q.pop_front();
          if (out_char !== want.chr) begin
            report_mismatch("out_char", int'(out_char), int'(want.chr));
          end
          if (run_last !== want.run_end) begin
            report_mismatch("run_last", int'(run_last), int'(want.run_end));
          end
          if (image_done !== want.img_end) begin
            report_mismatch("image_done", int'(image_done), int'(want.img_end));
          end
        end
        char_count++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Output back-pressure in phases: none, light, heavy
  always @(negedge clk) begin
    int unsigned mode;
    int unsigned r;
    logic        stall_now;
    cyc_count++;
    stall_now = 1'b0;
    if (stall_left != 0) begin
      stall_now = 1'b1;
      stall_left--;
    end else begin
      mode = (cyc_count >> 7) % 3;
      r = $urandom_range(0, 99);
      if ((mode == 1 && r < 10) || (mode == 2 && r < 25)) begin
        stall_now = 1'b1;
        if ($urandom_range(0, 99) < 5) begin
          stall_left = $urandom_range(9, 39);
        end else begin
          stall_left = $urandom_range(0, 2);
        end
      end
    end
    out_stall <= stall_now;
  end

  function automatic int unsigned pick_gap(input int unsigned mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (mode == 0 || r < 75) begin
      return 0;
    end
    if (r < 96) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] v);
    int unsigned gap;
    @(negedge clk);
    in_valid <= 1'b1;
    data_byte <= v;
    do @(posedge clk); while (in_stall);
    total_sent++;
    image_sent++;
    gap = pick_gap((total_sent >> 6) % 3);
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_text();
    @(negedge clk);
    in_valid <= 1'b0;
    while (hex_text_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_start_address(input logic [31:0] v);
    drain_text();
    @(negedge clk);
    cfg_valid <= 1'b1;
    start_address <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_top_load_address();
    write_start_address(32'hFFFF_FFFF);
  endtask

  task automatic test_edge_bytes();
    logic [7:0] pattern[$];
    pattern = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA, 8'h0F, 8'hF0,
                8'h09, 8'h0A, 8'h90, 8'hA0, 8'h3C, 8'hC3, 8'hFF, 8'h00, 8'h10, 8'hEF};
    foreach (pattern[i]) begin
      send_byte(pattern[i]);
    end
  endtask

  task automatic test_random_bytes(input int unsigned upto);
    while (image_sent < upto) begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_config_mid_image();
    write_start_address($urandom());
    write_start_address(32'h8000_0000);
    write_start_address(32'h0000_0000);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    cfg_valid = 1'b0;
    start_address = '0;
    err_count = 0;
    char_count = 0;
    total_sent = 0;
    image_sent = 0;
    quiet_cycles = 0;
    cyc_count = 0;
    stall_left = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_top_load_address();
    test_edge_bytes();
    test_random_bytes(200);
    test_config_mid_image();
    test_random_bytes(400);

    drain_text();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (hex_text_q.size() != 0) begin
      report_mismatch("missing chars", hex_text_q.size(), 0);
    end
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
